FILE: hw/rtl/box_blur_3x3_rgb_defines.svh
// Assertion macros for the 3x3 box blur block.
// No dependencies; included by the top level.
`ifndef BOX_BLUR_3X3_RGB_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_DEFINES_SVH
`ifndef ASSERT_OFF
`define BB_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("bb check");
`define BB_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("bb check");
`else
`define BB_ASSERT_IMPL(lbl, a, c)
`define BB_ASSERT_NEXT(lbl, a, c)
`endif
`endif

FILE: hw/rtl/bb3_pkg.sv
// Shared types and constants for the 3x3 box blur.
// No dependencies.
package bb3_pkg;
  localparam int MaxWidth   = 1024;
  localparam int SampleBits = 16;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = 12;
  localparam int PixW       = 3 * SampleBits;
  localparam int SumW       = SampleBits + 4;
  localparam logic [15:0] SMask = 16'((32'd1 << SampleBits) - 1);

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMax    = 2'd2;

  // Work handed from front to back
  typedef struct packed {
    logic            filt;
    logic            brd;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [PixW-1:0] cur;
    logic [PixW-1:0] up;
    logic [PixW-1:0] lo;
  } work_t;

  typedef struct packed {
    logic [RowW-1:0]       row;
    logic [ColW-1:0]       col;
    logic [PixW-1:0]       pix;
    logic                  last;
  } res_t;

  // Divide by 9 via reciprocal multiply: ceil(2^23/9), exact for sums below 2^21
  function automatic logic [SampleBits-1:0] div9(input logic [SumW-1:0] s);
    logic [SumW+19:0] p;
    begin
      p    = (SumW+20)'(s) * (SumW+20)'(20'd932068);
      div9 = SampleBits'(p >> 23);
    end
  endfunction
endpackage

FILE: hw/rtl/bb3_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module bb3_ram #(
  parameter int Width = 48,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/bb3_front.sv
// Front: position tracking, line stores, classification of each pixel.
// Depends on bb3_pkg and bb3_ram.
module bb3_front import bb3_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [10:0]     cfg_w,
  input  logic [12:0]     cfg_h,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [PixW-1:0] in_pix,
  output logic            wk_valid,
  input  logic            wk_ready,
  output work_t           wk
);
  logic [RowW-1:0] row_r, row_nxt;
  logic [ColW-1:0] col_r, col_nxt;
  logic [ColW-1:0] wl, r_c;
  logic [RowW-1:0] hl, r_r;
  logic [ColW:0]   wsat;
  logic [RowW:0]   hsat;
  logic            acc;
  // stage 1 registers
  logic            s1_v_r, s1_v_nxt;
  logic            s1_f_r, s1_b_r;
  logic [RowW-1:0] s1_row_r;
  logic [ColW-1:0] s1_col_r;
  logic [PixW-1:0] s1_cur_r;
  logic [PixW-1:0] up_q, lo_q;
  logic            s1_adv;
  // bypass: same column written since read? (width >= 3 so never)

  always_comb begin
    wsat = (cfg_w < 11'd3) ? (ColW+1)'(3) :
           (cfg_w > 11'(MaxWidth)) ? (ColW+1)'(MaxWidth) : (ColW+1)'(cfg_w);
    hsat = (cfg_h < 13'd3) ? 13'd3 : (cfg_h > 13'd4096) ? 13'd4096 : cfg_h;
    wl   = ColW'(wsat - 1'b1);
    hl   = RowW'(hsat - 1'b1);
    r_r  = (row_r < hl) ? row_r : hl;
    r_c  = (col_r < wl) ? col_r : wl;
  end

  assign s1_adv   = !s1_v_r || wk_ready;
  assign in_ready = s1_adv;
  assign acc      = in_valid && in_ready;

  // next position
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (acc) begin
      if (r_c >= wl) begin
        col_nxt = '0;
        row_nxt = (r_r >= hl) ? '0 : r_r + 1'b1;
      end else begin
        col_nxt = r_c + 1'b1;
        row_nxt = r_r;
      end
    end
    s1_v_nxt = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_f_r   <= (r_r >= 12'd2) && (r_c >= 10'd2);
      s1_b_r   <= (r_r == '0) || (r_r == hl) || (r_c == '0) || (r_c == wl);
      s1_row_r <= r_r;
      s1_col_r <= r_c;
      s1_cur_r <= in_pix;
    end
  end

  // line stores: upper gets old lower, lower gets current
  bb3_ram #(.Width(PixW), .Depth(MaxWidth)) u_up (
    .clk, .we(s1_v_r && s1_adv), .waddr(s1_col_r), .wdata(lo_q),
    .re(acc), .raddr(r_c), .rdata(up_q));
  bb3_ram #(.Width(PixW), .Depth(MaxWidth)) u_lo (
    .clk, .we(s1_v_r && s1_adv), .waddr(s1_col_r), .wdata(s1_cur_r),
    .re(acc), .raddr(r_c), .rdata(lo_q));

  assign wk_valid = s1_v_r;
  always_comb begin
    wk.filt = s1_f_r;
    wk.brd  = s1_b_r;
    wk.row  = s1_row_r;
    wk.col  = s1_col_r;
    wk.cur  = s1_cur_r;
    wk.up   = up_q;
    wk.lo   = lo_q;
  end
endmodule

FILE: hw/rtl/bb3_fifo.sv
// Two-entry queue between front and back.
// Depends on bb3_pkg.
module bb3_fifo import bb3_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  i_valid,
  output logic  i_ready,
  input  work_t i_data,
  output logic  o_valid,
  input  logic  o_ready,
  output work_t o_data
);
  work_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  assign i_ready = cnt_r != 2'd2;
  assign o_valid = cnt_r != 2'd0;
  assign o_data  = mem_r[rp_r];
  assign push    = i_valid && i_ready;
  assign pop     = o_valid && o_ready;
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= i_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: hw/rtl/bb3_back.sv
// Back: sliding window, 3x3 sums, divide by 9, clamp, result emission.
// Depends on bb3_pkg.
module bb3_back import bb3_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [15:0]     cfg_max,
  input  logic            wk_valid,
  output logic            wk_ready,
  input  work_t           wk,
  output logic            out_valid,
  input  logic            out_ready,
  output res_t            res
);
  logic [PixW-1:0] win_r [6];
  // stage A: sums
  logic            a_v_r, a_f_r, a_b_r;
  logic [RowW-1:0] a_row_r;
  logic [ColW-1:0] a_col_r;
  logic [PixW-1:0] a_cur_r;
  logic [SumW-1:0] a_sum_r [3];
  logic            a_adv, take, phase_r;
  logic [15:0]     lim;
  logic [PixW-1:0] fpix;
  logic [SumW-1:0] s;
  logic            o_v_r;
  res_t            o_r;
  logic            two, emit_last, o_adv;

  assign o_adv = !o_v_r || out_ready;
  // result per cycle from stage A if o_adv; two results hold stage A
  assign two       = a_f_r && a_b_r;
  assign emit_last = !two || phase_r;
  assign a_adv     = !a_v_r || (o_adv && emit_last) || !(a_f_r || a_b_r);
  assign wk_ready  = a_adv;
  assign take      = wk_valid && wk_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 6; j++) win_r[j] <= '0;
    end else if (take) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= wk.up;
      win_r[4] <= wk.lo;
      win_r[5] <= wk.cur;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_f_r   <= wk.filt;
      a_b_r   <= wk.brd;
      a_row_r <= wk.row;
      a_col_r <= wk.col;
      a_cur_r <= wk.cur;
      for (int k = 0; k < 3; k++) begin
        a_sum_r[k] <= SumW'(wk.cur[k*SampleBits +: SampleBits])
          + SumW'(wk.up[k*SampleBits +: SampleBits])
          + SumW'(wk.lo[k*SampleBits +: SampleBits])
          + SumW'(win_r[0][k*SampleBits +: SampleBits])
          + SumW'(win_r[1][k*SampleBits +: SampleBits])
          + SumW'(win_r[2][k*SampleBits +: SampleBits])
          + SumW'(win_r[3][k*SampleBits +: SampleBits])
          + SumW'(win_r[4][k*SampleBits +: SampleBits])
          + SumW'(win_r[5][k*SampleBits +: SampleBits]);
      end
    end
  end

  assign lim = (cfg_max > SMask) ? SMask : cfg_max;
  always_comb begin
    fpix = '0;
    for (int k = 0; k < 3; k++) begin
      s = a_sum_r[k];
      fpix[k*SampleBits +: SampleBits] = (div9(s) > lim) ? lim : div9(s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      phase_r <= 1'b0;
      o_v_r   <= 1'b0;
    end else begin
      if (a_adv) a_v_r <= take;
      if (a_v_r && (a_f_r || a_b_r) && o_adv)
        phase_r <= two && !phase_r;
      if (o_adv) o_v_r <= a_v_r && (a_f_r || a_b_r);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (o_adv && a_v_r) begin
      if (a_f_r && !phase_r) begin
        o_r.row <= a_row_r - 1'b1;
        o_r.col <= a_col_r - 1'b1;
        o_r.pix <= fpix;
      end else begin
        o_r.row <= a_row_r;
        o_r.col <= a_col_r;
        o_r.pix <= a_cur_r;
      end
      o_r.last <= emit_last;
    end
  end

  assign out_valid = o_v_r;
  assign res       = o_r;
endmodule

FILE: hw/rtl/box_blur_3x3_rgb.sv
// Top level of the 3x3 box blur: config registers, front, queue, back.
// Depends on bb3_pkg, bb3_front, bb3_fifo, bb3_back and the defines header.
// Usage:
//   Pixels enter on in_* with valid/ready in raster order, one beat each.
//   Results leave on out_* with valid/ready, each tagged with row and col.
//   An interior pixel (r-1,c-1) is emitted after pixel (r,c) arrives, then
//   the border pixel (r,c) itself if it lies on the frame edge; run_last
//   marks the final result caused by an input beat.
//   Throughput: one pixel per cycle while out_ready is high; an input causing
//   two results holds the input side while both pass its single result port.
//   Each result passes the front register, a queue entry, the sum stage and
//   the output register. Geometry and clamp are set over the cfg APB port;
//   the user sets them only while idle, which the block does not enforce.
//   Reset (synchronous, rst_n low) restores 640x480, clamp 255, clears the
//   window and position; line stores stay unwritten and need no clearing.
//   When the receiver stalls, the output register holds, the queue fills,
//   and in_ready drops; nothing is lost.
`include "box_blur_3x3_rgb_defines.svh"
module box_blur_3x3_rgb import bb3_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_red_in,
  input  logic [15:0] in_green_in,
  input  logic [15:0] in_blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_out_row,
  output logic [9:0]  out_out_col,
  output logic [15:0] out_red_out,
  output logic [15:0] out_green_out,
  output logic [15:0] out_blue_out,
  output logic        out_run_last
);
  logic [10:0] w_r;
  logic [12:0] h_r;
  logic [15:0] m_r;
  logic        wr;
  logic [1:0]  ridx;
  logic        f_v, f_rdy, q_v, q_rdy;
  work_t       f_w, q_w;
  res_t        res;
  logic [PixW-1:0] in_pix;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[3:2];
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[0] && !cfg_paddr[1];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 11'd640;
      h_r <= 13'd480;
      m_r <= 16'd255;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        RegWidth:  w_r <= cfg_pwdata[10:0];
        RegHeight: h_r <= cfg_pwdata[12:0];
        RegMax:    m_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegWidth:  cfg_prdata = {21'd0, w_r};
      RegHeight: cfg_prdata = {19'd0, h_r};
      RegMax:    cfg_prdata = {16'd0, m_r};
      default:   cfg_prdata = '0;
    endcase
  end

  assign in_pix = {in_blue_in & SMask, in_green_in & SMask, in_red_in & SMask};

  bb3_front u_front (.clk, .rst_n, .cfg_w(w_r), .cfg_h(h_r),
    .in_valid, .in_ready, .in_pix, .wk_valid(f_v), .wk_ready(f_rdy), .wk(f_w));
  bb3_fifo u_fifo (.clk, .rst_n, .i_valid(f_v), .i_ready(f_rdy), .i_data(f_w),
    .o_valid(q_v), .o_ready(q_rdy), .o_data(q_w));
  bb3_back u_back (.clk, .rst_n, .cfg_max(m_r), .wk_valid(q_v), .wk_ready(q_rdy),
    .wk(q_w), .out_valid, .out_ready, .res);

  assign out_out_row   = res.row;
  assign out_out_col   = res.col;
  assign out_red_out   = res.pix[15:0];
  assign out_green_out = res.pix[31:16];
  assign out_blue_out  = res.pix[47:32];
  assign out_run_last  = res.last;

  `BB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res))
  `BB_ASSERT_NEXT(a_wk_hold, f_v && !f_rdy, f_v && $stable(f_w))
  `BB_ASSERT_IMPL(a_wr_idle, wr, !out_valid && !f_v && !q_v)
endmodule
